>>> hw/rtl/lkvc_pkg.sv
// Shared request/response types and constants for the LRU key-value cache.
`timescale 1ns / 1ps
package lkvc_pkg;

  localparam int CFG_BITS = 5;
  localparam logic [CFG_BITS-1:0] CAP_RESET = 5'd16;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_SET = 1'b1;

  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  typedef struct packed {
    logic              req_type;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic signed [31:0] read_value;
  } rsp_t;

endpackage

>>> hw/rtl/lkvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/lkvc_front.sv
// Front end: takes requests and holds them in a two-entry queue for the back end.
`timescale 1ns / 1ps
module lkvc_front import lkvc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic job_valid,
  input  logic job_ready,
  output req_t job
);

  req_t       q_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       push;
  logic       pop;

  assign in_ready  = (cnt_r != 2'd2);
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        q_r[wp_r] <= in_req;
        wp_r      <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

>>> hw/rtl/lkvc_back.sv
// Back end: scans the store for a key and free slot, then applies get/set with LRU update.
`timescale 1ns / 1ps
module lkvc_back import lkvc_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [CW-1:0] cap_eff,
  input  logic          job_valid,
  output logic          job_ready,
  input  req_t          job,
  output logic          out_valid,
  input  logic          out_ready,
  output rsp_t          out_rsp
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_DRAIN, ST_APPLY, ST_READ, ST_OUT
  } state_t;

  state_t                state_r;
  logic [IW-1:0]         cnt_r;
  logic                  cmp_vld_r;
  logic [IW-1:0]         cmp_idx_r;
  logic                  set_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  found_r;
  logic [IW-1:0]         hit_idx_r;
  logic                  free_found_r;
  logic [IW-1:0]         free_idx_r;
  logic [CAPACITY-1:0]   valid_r;
  logic [IW-1:0]         rank_r [CAPACITY];
  logic [CW-1:0]         used_r;
  rsp_t                  rsp_r;

  logic [KEY_BITS-1:0]   key_rdata;
  logic [VALUE_BITS-1:0] val_rdata;
  logic [63:0]           key64;
  logic [63:0]           val64;
  logic [63:0]           rd64;
  logic                  evict;
  logic [CW-1:0]         capm1;
  logic                  cmp_valid;
  logic [IW-1:0]         cmp_rank;
  logic                  cmp_match;
  logic                  cmp_free;
  logic [IW-1:0]         hit_rank;
  logic                  key_we;
  logic                  val_we;
  logic [IW-1:0]         val_waddr;

  assign key64     = 64'($unsigned(job.key));
  assign val64     = 64'($unsigned(job.value));
  assign rd64      = 64'(val_rdata);
  assign evict     = (used_r >= cap_eff);
  assign capm1     = cap_eff - CW'(1);
  assign cmp_valid = valid_r[cmp_idx_r];
  assign cmp_rank  = rank_r[cmp_idx_r];
  assign cmp_match = cmp_vld_r && cmp_valid && (key_rdata == key_r);
  // a slot counts as free if empty, or if the pending eviction will empty it
  assign cmp_free  = cmp_vld_r && (!cmp_valid || (evict && (CW'(cmp_rank) >= capm1)));
  assign hit_rank  = rank_r[hit_idx_r];

  assign job_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_rsp   = rsp_r;

  assign key_we    = (state_r == ST_APPLY) && set_r && !found_r;
  assign val_we    = (state_r == ST_APPLY) && set_r;
  assign val_waddr = found_r ? hit_idx_r : free_idx_r;

  lkvc_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (free_idx_r),
    .wdata (key_r),
    .raddr (cnt_r),
    .rdata (key_rdata)
  );

  lkvc_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_r),
    .raddr (hit_idx_r),
    .rdata (val_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cmp_vld_r <= 1'b0;
      valid_r   <= '0;
      used_r    <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      cmp_vld_r <= 1'b0;
      cmp_idx_r <= cnt_r;
      if (cmp_match && !found_r) begin
        found_r   <= 1'b1;
        hit_idx_r <= cmp_idx_r;
      end
      if (cmp_free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            set_r        <= (job.req_type == REQ_SET);
            key_r        <= key64[KEY_BITS-1:0];
            val_r        <= val64[VALUE_BITS-1:0];
            cnt_r        <= '0;
            found_r      <= 1'b0;
            free_found_r <= 1'b0;
            state_r      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_vld_r <= 1'b1;
          cnt_r     <= cnt_r + IW'(1);
          if (cnt_r == IW'(CAPACITY - 1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_APPLY;
        end
        ST_APPLY: begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (found_r) begin
              // touch: younger entries age by one, hit entry becomes newest
              if (IW'(i) == hit_idx_r) begin
                rank_r[i] <= '0;
              end else if (valid_r[i] && (rank_r[i] < hit_rank)) begin
                rank_r[i] <= rank_r[i] + IW'(1);
              end
            end else if (set_r) begin
              if (IW'(i) == free_idx_r) begin
                valid_r[i] <= 1'b1;
                rank_r[i]  <= '0;
              end else if (valid_r[i] && evict && (CW'(rank_r[i]) >= capm1)) begin
                valid_r[i] <= 1'b0;
                rank_r[i]  <= '0;
              end else if (valid_r[i]) begin
                rank_r[i] <= rank_r[i] + IW'(1);
              end
            end
          end
          if (set_r && !found_r) begin
            used_r <= (evict ? capm1 : used_r) + CW'(1);
          end
          if (set_r) begin
            state_r <= ST_IDLE;
          end else if (found_r) begin
            state_r <= ST_READ;
          end else begin
            rsp_r.hit        <= 1'b0;
            rsp_r.read_value <= MISS_VALUE;
            state_r          <= ST_OUT;
          end
        end
        ST_READ: begin
          rsp_r.hit        <= 1'b1;
          rsp_r.read_value <= rd64[31:0];
          state_r          <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_used_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == used_r)
    else $error("used count disagrees with valid bits");

  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(CAPACITY))
    else $error("used count above store size");

  a_result_only_get: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !set_r)
    else $error("result raised for a set request");

  a_drain_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN |-> $past(state_r) == ST_SCAN)
    else $error("drain entered without scan");

endmodule

>>> hw/rtl/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key-value cache.
`timescale 1ns / 1ps
// Fully associative key-value cache with least-recently-used replacement.
// A get request returns one response (hit plus stored value, or miss with
// read_value all ones); a set request updates or inserts and returns nothing.
// Requests pass through a two-entry queue to a back end that walks all
// CAPACITY slots of the key RAM, one per cycle, to find the key and a free
// slot, then applies the request and, for a get, holds the response until
// out_ready. The back end takes no new request until done with the last.
// The capacity register (reset 16) limits entries in use; 0 acts as 1 and
// values above CAPACITY act as CAPACITY. Write it only while the cache is
// idle. Lowering it takes effect on the next inserting set, which evicts
// the oldest entries down to capacity-1 first. The store is empty after
// reset; no clearing pass is needed.
module lru_key_value_cache_core import lkvc_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  req_t                in_req,
  output logic                out_valid,
  input  logic                out_ready,
  output rsp_t                out_rsp,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > CFG_BITS) ? CW : CFG_BITS;

  logic [CFG_BITS-1:0] capacity_r;
  logic [MW-1:0]       cap_wide;
  logic [MW-1:0]       cap_clamp;
  logic [CW-1:0]       cap_eff;
  logic                job_valid;
  logic                job_ready;
  req_t                job;

  // capacity register, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  // clamp to 1..CAPACITY
  assign cap_wide = MW'(capacity_r);
  always_comb begin
    priority if (cap_wide == '0) begin
      cap_clamp = MW'(1);
    end else if (cap_wide > MW'(CAPACITY)) begin
      cap_clamp = MW'(CAPACITY);
    end else begin
      cap_clamp = cap_wide;
    end
  end
  assign cap_eff = cap_clamp[CW-1:0];

  lkvc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  lkvc_back #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cap_eff   (cap_eff),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rsp   (out_rsp)
  );

endmodule
